[hw/rtl/mrpla_pkg.sv]
// Shared definitions for the minimum-request power limit arbiter.
// Item kind codes, quantity count and controller state type; no dependencies.
package mrpla_pkg;

   // number of arbitrated quantities: power limit, time window, duty cycle
   localparam int QUANTITIES = 3;

   // item kinds
   localparam logic [1:0] KIND_COMMIT = 2'd0;
   localparam logic [1:0] KIND_WHATIF = 2'd1;
   localparam logic [1:0] KIND_REMOVE = 2'd2;
   localparam logic [1:0] KIND_READ   = 2'd3;

   // controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_START,
      ST_SCAN,
      ST_SCAN_END,
      ST_SWEEP,
      ST_SWEEP_END,
      ST_APPLY,
      ST_ARB_RD,
      ST_ARB_WAIT,
      ST_DONE
   } state_type;

endpackage

[hw/rtl/min_request_power_limit_arbiter.sv]
// Minimum-request arbiter: request store and arbitrated store in block memories.
// Depends on mrpla_pkg (kind codes, quantity count, state type).
//
//  channel | direction | ports                                            | transfer
//  --------+-----------+--------------------------------------------------+----------------
//  req     | in        | kind, quantity, requester, control_type, value    | valid && ready
//  rsp     | out       | answer_value, answer_valid                       | valid && ready
//
// Work per item: commit and what-if read the request store once per requester of
// the addressed pair; read, and commit or remove with nothing to act on, read the
// arbitrated store; what-if with an invalid pair or requester answers invalid with
// no memory read; remove sweeps the request store one quantity at a time, each sweep
// followed by a step per control type that updates the arbitrated store.
// After reset a clearing pass over every request-store entry zeroes
// both memories; no item is taken until it ends.
// One item is in work at a time; a finished result sits in the output register
// while the next item is taken, and waits internally if that register is full.
module min_request_power_limit_arbiter #(
   parameter int REQUESTERS    = 16,
   parameter int CONTROL_TYPES = 4,
   parameter int VALUE_WIDTH   = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_kind,
   input  logic [1:0]  req_quantity,
   input  logic [3:0]  req_requester,
   input  logic [1:0]  req_control_type,
   input  logic [31:0] req_request_value,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_answer_value,
   output logic        rsp_answer_valid
);
   import mrpla_pkg::*;

   localparam int RT          = REQUESTERS * CONTROL_TYPES;
   localparam int ENTRIES     = QUANTITIES * RT;
   localparam int ARB_ENTRIES = QUANTITIES * CONTROL_TYPES;
   localparam int RA_W        = $clog2(ENTRIES);
   localparam int AA_W        = $clog2(ARB_ENTRIES);
   localparam int R_W         = (REQUESTERS > 1) ? $clog2(REQUESTERS) : 1;
   localparam int T_W         = (CONTROL_TYPES > 1) ? $clog2(CONTROL_TYPES) : 1;
   localparam int VW          = VALUE_WIDTH;

   localparam logic [RA_W-1:0] LAST_ENTRY = RA_W'(ENTRIES - 1);
   localparam logic [R_W-1:0]  LAST_REQ   = R_W'(REQUESTERS - 1);
   localparam logic [T_W-1:0]  LAST_TYPE  = T_W'(CONTROL_TYPES - 1);
   localparam logic [1:0]      LAST_QTY   = 2'(QUANTITIES - 1);

   // memories: bit VW is the valid mark
   logic [VW:0] req_mem [ENTRIES];
   logic [VW:0] arb_mem [ARB_ENTRIES];

   // control registers
   state_type       state_ff, state_in;
   logic [RA_W-1:0] clr_ff, clr_in;
   logic            rd_vld_ff, rd_vld_in;
   logic            rsp_valid_ff, rsp_valid_in;

   // item fields
   logic [1:0]    kind_ff, kind_in;
   logic [1:0]    q_ff, q_in;
   logic [3:0]    r_ff, r_in;
   logic [1:0]    t_ff, t_in;
   logic [VW-1:0] v_ff, v_in;

   // walk counters and read tags
   logic [RA_W-1:0] addr_ff, addr_in;
   logic [R_W-1:0]  k_ff, k_in;
   logic [T_W-1:0]  t_s_ff, t_s_in;
   logic [T_W-1:0]  at_ff, at_in;
   logic [1:0]      q_s_ff, q_s_in;
   logic [R_W-1:0]  rd_k_ff, rd_k_in;
   logic [T_W-1:0]  rd_t_ff, rd_t_in;
   logic [RA_W-1:0] rd_addr_ff, rd_addr_in;
   logic [VW:0]     rdata_ff;
   logic [VW:0]     arb_rdata_ff;

   // running minimum and result
   logic [VW-1:0] min_ff, min_in;
   logic [VW-1:0] res_value_ff, res_value_in;
   logic          res_valid_ff, res_valid_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;
   logic          rsp_avalid_ff, rsp_avalid_in;

   // per-type lanes of a remove sweep
   logic [VW-1:0]            lmin_ff [CONTROL_TYPES];
   logic [CONTROL_TYPES-1:0] lfound_ff;
   logic [CONTROL_TYPES-1:0] had_ff;
   logic                     any_ff;

   // memory port controls
   logic            req_we, req_re;
   logic [RA_W-1:0] req_waddr;
   logic [VW:0]     req_wdata;
   logic            arb_we, arb_re;
   logic [AA_W-1:0] arb_waddr;
   logic [VW:0]     arb_wdata;

   logic            lane_clr, lane_upd, rsp_load;
   logic            pair_ok, req_in, rd_own, scan_hit;
   logic [VW-1:0]   scan_min, lmin_rd;
   logic [T_W-1:0]  lane_idx;
   logic [RA_W-1:0] entry_addr, scan_base;
   logic [AA_W-1:0] arb_addr, apply_addr;
   logic [63:0]     v_wide, res_wide;

   // decode of the held item
   assign pair_ok    = (32'(q_ff) < QUANTITIES) && (32'(t_ff) < CONTROL_TYPES);
   assign req_in     = 32'(r_ff) < REQUESTERS;
   assign entry_addr = RA_W'(32'(q_ff) * RT + 32'(r_ff) * CONTROL_TYPES + 32'(t_ff));
   assign scan_base  = RA_W'(32'(q_ff) * RT + 32'(t_ff));
   assign arb_addr   = AA_W'(32'(q_ff) * CONTROL_TYPES + 32'(t_ff));
   assign apply_addr = AA_W'(32'(q_s_ff) * CONTROL_TYPES + 32'(at_ff));

   // returned read data: own entry, and running minimum of a scan
   assign rd_own   = 32'(rd_k_ff) == 32'(r_ff);
   assign scan_hit = rd_vld_ff && !rd_own && rdata_ff[VW] && (rdata_ff[VW-1:0] < min_ff);
   assign scan_min = scan_hit ? rdata_ff[VW-1:0] : min_ff;

   assign lane_idx = (state_ff == ST_APPLY) ? at_ff : rd_t_ff;
   assign lmin_rd  = lmin_ff[lane_idx];

   assign v_wide   = 64'(req_request_value);
   assign res_wide = 64'(res_value_ff);

   assign req_ready        = state_ff == ST_IDLE;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_answer_value = rsp_value_ff;
   assign rsp_answer_valid = rsp_avalid_ff;

   // next state, datapath next values and memory port controls
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      rd_vld_in     = 1'b0;
      kind_in       = kind_ff;
      q_in          = q_ff;
      r_in          = r_ff;
      t_in          = t_ff;
      v_in          = v_ff;
      addr_in       = addr_ff;
      k_in          = k_ff;
      t_s_in        = t_s_ff;
      at_in         = at_ff;
      q_s_in        = q_s_ff;
      rd_k_in       = rd_k_ff;
      rd_t_in       = rd_t_ff;
      rd_addr_in    = rd_addr_ff;
      min_in        = min_ff;
      res_value_in  = res_value_ff;
      res_valid_in  = res_valid_ff;
      req_we        = 1'b0;
      req_re        = 1'b0;
      req_waddr     = rd_addr_ff;
      req_wdata     = '0;
      arb_we        = 1'b0;
      arb_re        = 1'b0;
      arb_waddr     = apply_addr;
      arb_wdata     = '0;
      lane_clr      = 1'b0;
      lane_upd      = 1'b0;
      rsp_load      = 1'b0;

      case (state_ff)
         ST_CLEAR: begin
            req_we    = 1'b1;
            req_waddr = clr_ff;
            arb_we    = 32'(clr_ff) < ARB_ENTRIES;
            arb_waddr = clr_ff[AA_W-1:0];
            clr_in    = clr_ff + RA_W'(1);
            if (clr_ff == LAST_ENTRY) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               q_in     = req_quantity;
               r_in     = req_requester;
               t_in     = req_control_type;
               v_in     = v_wide[VW-1:0];
               state_in = ST_START;
            end
         end
         ST_START: begin
            case (kind_ff)
               KIND_COMMIT, KIND_WHATIF: begin
                  if (pair_ok && req_in) begin
                     addr_in  = scan_base;
                     k_in     = '0;
                     min_in   = v_ff;
                     state_in = ST_SCAN;
                     // commit stores its entry up front; the scan substitutes it
                     if (kind_ff == KIND_COMMIT) begin
                        req_we    = 1'b1;
                        req_waddr = entry_addr;
                        req_wdata = {1'b1, v_ff};
                     end
                  end else if (kind_ff == KIND_WHATIF) begin
                     res_value_in = '0;
                     res_valid_in = 1'b0;
                     state_in     = ST_DONE;
                  end else begin
                     state_in = ST_ARB_RD;
                  end
               end
               KIND_REMOVE: begin
                  if (req_in) begin
                     addr_in  = '0;
                     k_in     = '0;
                     t_s_in   = '0;
                     q_s_in   = '0;
                     lane_clr = 1'b1;
                     state_in = ST_SWEEP;
                  end else begin
                     state_in = ST_ARB_RD;
                  end
               end
               default: begin
                  state_in = ST_ARB_RD;
               end
            endcase
         end
         // one requester per cycle for the addressed pair
         ST_SCAN: begin
            req_re    = 1'b1;
            rd_vld_in = 1'b1;
            rd_k_in   = k_ff;
            addr_in   = addr_ff + RA_W'(CONTROL_TYPES);
            k_in      = k_ff + R_W'(1);
            min_in    = scan_min;
            if (k_ff == LAST_REQ) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: begin
            if (kind_ff == KIND_COMMIT) begin
               arb_we    = 1'b1;
               arb_waddr = arb_addr;
               arb_wdata = {1'b1, scan_min};
            end
            res_value_in = scan_min;
            res_valid_in = 1'b1;
            state_in     = ST_DONE;
         end
         // remove: walk one quantity, dropping the requester's entries
         ST_SWEEP: begin
            req_re     = 1'b1;
            rd_vld_in  = 1'b1;
            rd_k_in    = k_ff;
            rd_t_in    = t_s_ff;
            rd_addr_in = addr_ff;
            addr_in    = addr_ff + RA_W'(1);
            lane_upd   = rd_vld_ff;
            req_we     = rd_vld_ff && rd_own;
            if (t_s_ff == LAST_TYPE) begin
               t_s_in = '0;
               if (k_ff == LAST_REQ) begin
                  k_in     = '0;
                  state_in = ST_SWEEP_END;
               end else begin
                  k_in = k_ff + R_W'(1);
               end
            end else begin
               t_s_in = t_s_ff + T_W'(1);
            end
         end
         ST_SWEEP_END: begin
            lane_upd = rd_vld_ff;
            req_we   = rd_vld_ff && rd_own;
            at_in    = '0;
            state_in = ST_APPLY;
         end
         // one arbitrated entry of the quantity per cycle
         ST_APPLY: begin
            if (|had_ff) begin
               if (any_ff) begin
                  arb_we    = had_ff[at_ff] && lfound_ff[at_ff];
                  arb_wdata = {1'b1, lmin_rd};
               end else begin
                  arb_we = 1'b1;
               end
            end
            at_in = at_ff + T_W'(1);
            if (at_ff == LAST_TYPE) begin
               if (q_s_ff == LAST_QTY) begin
                  state_in = ST_ARB_RD;
               end else begin
                  q_s_in   = q_s_ff + 2'd1;
                  lane_clr = 1'b1;
                  state_in = ST_SWEEP;
               end
            end
         end
         ST_ARB_RD: begin
            arb_re   = 1'b1;
            state_in = ST_ARB_WAIT;
         end
         ST_ARB_WAIT: begin
            res_valid_in = pair_ok && arb_rdata_ff[VW];
            res_value_in = (pair_ok && arb_rdata_ff[VW]) ? arb_rdata_ff[VW-1:0] : '0;
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_value_in  = rsp_value_ff;
      rsp_avalid_in = rsp_avalid_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_value_in  = res_wide[31:0];
         rsp_avalid_in = res_valid_ff;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_ff       <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      q_ff          <= q_in;
      r_ff          <= r_in;
      t_ff          <= t_in;
      v_ff          <= v_in;
      addr_ff       <= addr_in;
      k_ff          <= k_in;
      t_s_ff        <= t_s_in;
      at_ff         <= at_in;
      q_s_ff        <= q_s_in;
      rd_k_ff       <= rd_k_in;
      rd_t_ff       <= rd_t_in;
      rd_addr_ff    <= rd_addr_in;
      min_ff        <= min_in;
      res_value_ff  <= res_value_in;
      res_valid_ff  <= res_valid_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_avalid_ff <= rsp_avalid_in;
   end

   // sweep lanes: what the requester held, and the minimum of the others
   always_ff @(posedge clock) begin
      if (lane_clr) begin
         had_ff    <= '0;
         lfound_ff <= '0;
         any_ff    <= 1'b0;
      end else if (lane_upd) begin
         if (rd_own) begin
            had_ff[rd_t_ff] <= had_ff[rd_t_ff] | rdata_ff[VW];
         end else if (rdata_ff[VW]) begin
            any_ff <= 1'b1;
            if (!lfound_ff[rd_t_ff] || (rdata_ff[VW-1:0] < lmin_rd)) begin
               lmin_ff[rd_t_ff]   <= rdata_ff[VW-1:0];
               lfound_ff[rd_t_ff] <= 1'b1;
            end
         end
      end
   end

   // request store
   always_ff @(posedge clock) begin
      if (req_we) begin
         req_mem[req_waddr] <= req_wdata;
      end
      if (req_re) begin
         rdata_ff <= req_mem[addr_ff];
      end
   end

   // arbitrated store
   always_ff @(posedge clock) begin
      if (arb_we) begin
         arb_mem[arb_waddr] <= arb_wdata;
      end
      if (arb_re) begin
         arb_rdata_ff <= arb_mem[arb_addr];
      end
   end

   // read data only returns into a state that consumes it
   a_rd_consumed: assert property (@(posedge clock) disable iff (reset)
      rd_vld_ff |-> (state_ff == ST_SCAN || state_ff == ST_SCAN_END ||
                     state_ff == ST_SWEEP || state_ff == ST_SWEEP_END))
      else $error("request-store read data returned outside a walk");

   // each quantity of a remove starts with empty lanes
   a_lanes_fresh: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SWEEP && $past(state_ff) == ST_APPLY) |-> (had_ff == '0 && !any_ff))
      else $error("sweep lanes not cleared between quantities");

   // the clearing pass covers the whole request store
   a_clear_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && $past(state_ff) == ST_CLEAR) |-> ($past(clr_ff) == LAST_ENTRY))
      else $error("clearing pass left early");

endmodule
